// ===== design/las_pkg.sv =====
package las_pkg;

    // Default grid limits, handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_SIZE_W = 7;
    localparam logic [CFG_SIZE_W-1:0] CFG_SIZE_RESET = 7'd64;

    // Live neighbour count, 0..8.
    localparam int CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_WRAP_EDGES  = 2'd2
    } las_cfg_t;

    // Request codes; code 3 is a no-op that still returns a word.
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_NONE    = 2'd3
    } las_req_t;

    // Where a row entering the window comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_SAVE
    } las_src_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } las_state_t;

    typedef struct packed {
        las_req_t   req_type;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_value;
    } las_req_word_t;

    typedef struct packed {
        logic             read_value;
        logic [CNT_W-1:0] neighbor_count;
        logic             request_done;
    } las_rsp_word_t;

    // Control handed from the sequencer to the row of cells.
    typedef struct packed {
        logic shift;
        logic wrap;
    } las_row_ctrl_t;

endpackage

// ===== design/las_cell.sv =====
// One grid column: a three-row vertical window plus the B3/S23 rule.
module las_cell (
    input  logic                     clk,
    input  logic                     shift,
    input  logic                     in_bit,
    input  logic [2:0]               left_win,
    input  logic [2:0]               right_win,
    input  logic                     active,
    output logic [2:0]               win,
    output logic                     alive_next,
    output logic [las_pkg::CNT_W-1:0] count
);

    // win[2] row above, win[1] center row, win[0] row below
    logic [2:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_reg <= {win_reg[1:0], in_bit};
        end
    end

    assign win = win_reg;

    assign count = las_pkg::CNT_W'(left_win[0])  + las_pkg::CNT_W'(left_win[1])
                 + las_pkg::CNT_W'(left_win[2])  + las_pkg::CNT_W'(right_win[0])
                 + las_pkg::CNT_W'(right_win[1]) + las_pkg::CNT_W'(right_win[2])
                 + las_pkg::CNT_W'(win_reg[2])   + las_pkg::CNT_W'(win_reg[0]);

    assign alive_next = active &&
        ((count == las_pkg::CNT_W'(3)) || ((count == las_pkg::CNT_W'(2)) && win_reg[1]));

endmodule

// ===== design/las_row.sv =====
// Row of cells, one per column, each trading its window with both neighbors.
module las_row #(
    parameter int WIDTH = las_pkg::DEF_MAX_WIDTH,
    parameter int XW    = $clog2(WIDTH)
) (
    input  logic                      clk,
    input  las_pkg::las_row_ctrl_t    ctrl,
    input  logic [WIDTH-1:0]          row_in,
    input  logic [XW-1:0]             w_m1,
    input  logic [XW-1:0]             sel_x,
    output logic [WIDTH-1:0]          row_next,
    output logic                      sel_alive,
    output logic [las_pkg::CNT_W-1:0] sel_count
);

    logic [2:0]                win       [WIDTH];
    logic [2:0]                left_win  [WIDTH];
    logic [2:0]                right_win [WIDTH];
    logic [las_pkg::CNT_W-1:0] cnt       [WIDTH];
    logic [WIDTH-1:0]          mid_row;

    for (genvar c = 0; c < WIDTH; c++)
    begin : g_col
        logic active;

        assign active  = (XW'(c) <= w_m1);

        // column 0 sees the last used column only on a torus
        if (c == 0)
        begin : g_left_edge
            assign left_win[c] = ctrl.wrap ? win[w_m1] : 3'b000;
        end
        else
        begin : g_left
            assign left_win[c] = win[c-1];
        end

        if (c == WIDTH - 1)
        begin : g_right_edge
            assign right_win[c] = ctrl.wrap ? win[0] : 3'b000;
        end
        else
        begin : g_right
            logic is_last;

            assign is_last     = (XW'(c) == w_m1);
            assign right_win[c] = is_last ? (ctrl.wrap ? win[0] : 3'b000) : win[c+1];
        end

        las_cell u_cell (
            .clk        (clk),
            .shift      (ctrl.shift),
            .in_bit     (row_in[c]),
            .left_win   (left_win[c]),
            .right_win  (right_win[c]),
            .active     (active),
            .win        (win[c]),
            .alive_next (row_next[c]),
            .count      (cnt[c])
        );

        assign mid_row[c] = win[c][1];
    end

    assign sel_alive = mid_row[sel_x];
    assign sel_count = cnt[sel_x];

endmodule

// ===== design/life_automaton_step.sv =====
// Game of Life (B3/S23) engine. The grid is MAX_HEIGHT rows of MAX_WIDTH
// cells, of which grid_width x grid_height are in use (0 acts as 1, values
// above the maximum act as the maximum); wrap_edges picks dead borders or a
// torus. Each request word writes a cell, reads a cell with its live
// neighbour count, or advances one generation, and returns exactly one
// response word. Rows live in a single-port-read, single-port-write memory,
// one row per entry; a row of column cells holds a three-row window and
// evaluates a whole row per cycle. An advance is paced by the memory read
// port delivering one row per cycle (grid_height + 2 rows through the
// window) followed by zeroing of rows outside the grid in use. After reset
// the block zeroes the memory before taking requests; configuration writes
// are taken at any time.
module life_automaton_step #(
    parameter int MAX_WIDTH  = las_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = las_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           req_valid,
    output logic                           req_stall,
    input  las_pkg::las_req_word_t         req,
    // response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output las_pkg::las_rsp_word_t         rsp,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [las_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [las_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int SW0 = $clog2(MAX_WIDTH + 1);
    localparam int SH0 = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = (SW0 > las_pkg::CFG_SIZE_W) ? SW0 : las_pkg::CFG_SIZE_W;
    localparam int SH  = (SH0 > las_pkg::CFG_SIZE_W) ? SH0 : las_pkg::CFG_SIZE_W;
    // counts rows fed through the window, up to MAX_HEIGHT + 2
    localparam int CW  = $clog2(MAX_HEIGHT + 3);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [las_pkg::CFG_SIZE_W-1:0] grid_width_reg;
    logic [las_pkg::CFG_SIZE_W-1:0] grid_height_reg;
    logic                           wrap_edges_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= las_pkg::CFG_SIZE_RESET;
            grid_height_reg <= las_pkg::CFG_SIZE_RESET;
            wrap_edges_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                las_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                las_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                las_pkg::CFG_WRAP_EDGES:  wrap_edges_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamped sizes: width in [1, MAX_WIDTH], height in [1, MAX_HEIGHT]
    logic [SW-1:0] gw_ext;
    logic [SH-1:0] gh_ext;
    logic [SW-1:0] wc;
    logic [SH-1:0] hc;
    logic [XW-1:0] w_m1;
    logic [HW-1:0] h_m1;

    assign gw_ext = SW'(grid_width_reg);
    assign gh_ext = SH'(grid_height_reg);
    assign wc = (gw_ext == '0) ? SW'(1) :
                ((gw_ext > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : gw_ext);
    assign hc = (gh_ext == '0) ? SH'(1) :
                ((gh_ext > SH'(MAX_HEIGHT)) ? SH'(MAX_HEIGHT) : gh_ext);
    assign w_m1 = XW'(wc - SW'(1));
    assign h_m1 = HW'(hc - SH'(1));

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    las_pkg::las_state_t state_reg, state_next;

    // request held for the duration of the operation
    las_pkg::las_req_t op_reg;
    logic [XW-1:0]     x_idx_reg;
    logic [HW-1:0]     y_idx_reg;
    logic              value_reg;
    logic              inside_reg;

    // row stream: issue (memory read) -> feed (window shift) -> write back
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     fed_reg, fed_next;
    logic              feed_vld_reg, feed_vld_next;
    las_pkg::las_src_t feed_src_reg;
    logic              wb_vld_reg, wb_vld_next;
    logic [HW-1:0]     wb_row_reg;

    // zeroing sweep: after reset, and rows beyond the grid after an advance
    logic [HW-1:0]     clr_idx_reg, clr_idx_next;
    logic              clr_rsp_reg, clr_rsp_next;

    logic [MAX_WIDTH-1:0] rd_data_reg;
    logic [MAX_WIDTH-1:0] save_row_reg;

    logic                   rsp_valid_reg, rsp_valid_next;
    las_pkg::las_rsp_word_t rsp_reg;

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic              req_accept;
    logic              rsp_free;
    logic [CW-1:0]     n_items;
    logic              issuing;
    logic              feeding;
    logic              run_done;
    logic              clr_last;
    las_pkg::las_src_t iss_src;
    logic [HW-1:0]     iss_addr;
    logic              rd_en;
    logic              wr_en;
    logic [HW-1:0]     wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic [MAX_WIDTH-1:0] feed_row;
    logic [MAX_WIDTH-1:0] rmw_row;
    logic [MAX_WIDTH-1:0] row_next;
    logic              sel_alive;
    logic [las_pkg::CNT_W-1:0] sel_count;
    las_pkg::las_row_ctrl_t row_ctrl;

    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign feeding    = feed_vld_reg;
    assign clr_last   = (clr_idx_reg == HW'(MAX_HEIGHT - 1));

    // rows pushed through the window: advance needs a pad row at each end
    always_comb
    begin
        case (op_reg)
            las_pkg::REQ_ADVANCE: n_items = CW'(hc) + CW'(2);
            las_pkg::REQ_READ:    n_items = CW'(3);
            las_pkg::REQ_WRITE:   n_items = CW'(1);
            default:              n_items = '0;
        endcase
    end

    assign issuing  = (state_reg == las_pkg::ST_RUN) && (iss_reg < n_items);
    assign run_done = (iss_reg == n_items) && !feed_vld_reg && !wb_vld_reg;

    // Source of the row issued in this cycle. Pads above and below the
    // grid are zero on a dead border; on a torus they are the opposite row.
    always_comb
    begin
        iss_src  = las_pkg::SRC_ZERO;
        iss_addr = y_idx_reg;
        case (op_reg)
            las_pkg::REQ_ADVANCE:
            begin
                if (iss_reg == '0)
                begin
                    iss_src  = wrap_edges_reg ? las_pkg::SRC_MEM : las_pkg::SRC_ZERO;
                    iss_addr = h_m1;
                end
                else if (iss_reg <= CW'(hc))
                begin
                    iss_src  = las_pkg::SRC_MEM;
                    iss_addr = HW'(iss_reg - CW'(1));
                end
                else
                begin
                    // row 0 may have been overwritten by now, use the saved copy
                    iss_src = wrap_edges_reg ? las_pkg::SRC_SAVE : las_pkg::SRC_ZERO;
                end
            end
            las_pkg::REQ_READ:
            begin
                if (!inside_reg)
                begin
                    iss_src = las_pkg::SRC_ZERO;
                end
                else if (iss_reg == '0)
                begin
                    if (y_idx_reg == '0)
                    begin
                        iss_src  = wrap_edges_reg ? las_pkg::SRC_MEM : las_pkg::SRC_ZERO;
                        iss_addr = h_m1;
                    end
                    else
                    begin
                        iss_src  = las_pkg::SRC_MEM;
                        iss_addr = y_idx_reg - HW'(1);
                    end
                end
                else if (iss_reg == CW'(1))
                begin
                    iss_src  = las_pkg::SRC_MEM;
                    iss_addr = y_idx_reg;
                end
                else
                begin
                    if (y_idx_reg == h_m1)
                    begin
                        iss_src  = wrap_edges_reg ? las_pkg::SRC_MEM : las_pkg::SRC_ZERO;
                        iss_addr = '0;
                    end
                    else
                    begin
                        iss_src  = las_pkg::SRC_MEM;
                        iss_addr = y_idx_reg + HW'(1);
                    end
                end
            end
            las_pkg::REQ_WRITE:
            begin
                iss_src = inside_reg ? las_pkg::SRC_MEM : las_pkg::SRC_ZERO;
            end
            default:
            begin
                iss_src = las_pkg::SRC_ZERO;
            end
        endcase
    end

    assign rd_en = issuing && (iss_src == las_pkg::SRC_MEM);

    always_comb
    begin
        case (feed_src_reg)
            las_pkg::SRC_MEM:  feed_row = rd_data_reg;
            las_pkg::SRC_SAVE: feed_row = save_row_reg;
            default:           feed_row = '0;
        endcase
    end

    // single-cell write is a read-modify-write of its row
    always_comb
    begin
        rmw_row            = rd_data_reg;
        rmw_row[x_idx_reg] = value_reg;
    end

    // memory write port: zeroing sweep, advance write-back, cell write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wb_row_reg;
        wr_data = row_next;
        if (state_reg == las_pkg::ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end
        else if (wb_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wb_row_reg;
            wr_data = row_next;
        end
        else if (feeding && (op_reg == las_pkg::REQ_WRITE) &&
                 (feed_src_reg == las_pkg::SRC_MEM))
        begin
            wr_en   = 1'b1;
            wr_addr = y_idx_reg;
            wr_data = rmw_row;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            las_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_rsp_reg ? las_pkg::ST_FINISH : las_pkg::ST_IDLE;
                end
            end
            las_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req.req_type == las_pkg::REQ_NONE) ?
                                 las_pkg::ST_FINISH : las_pkg::ST_RUN;
                end
            end
            las_pkg::ST_RUN:
            begin
                if (run_done)
                begin
                    if ((op_reg == las_pkg::REQ_ADVANCE) && (hc < SH'(MAX_HEIGHT)))
                    begin
                        state_next = las_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = las_pkg::ST_FINISH;
                    end
                end
            end
            las_pkg::ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = las_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = las_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and counters
    // ------------------------------------------------------------------
    always_comb
    begin
        req_stall      = (state_reg != las_pkg::ST_IDLE);
        iss_next       = iss_reg;
        fed_next       = fed_reg;
        feed_vld_next  = issuing;
        wb_vld_next    = feeding && (op_reg == las_pkg::REQ_ADVANCE) &&
                         (fed_reg >= CW'(2));
        clr_idx_next   = clr_idx_reg;
        clr_rsp_next   = clr_rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (req_accept)
        begin
            iss_next = '0;
            fed_next = '0;
        end
        if (issuing)
        begin
            iss_next = iss_reg + CW'(1);
        end
        if (feeding)
        begin
            fed_next = fed_reg + CW'(1);
        end

        case (state_reg)
            las_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    clr_rsp_next = 1'b0;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + HW'(1);
                end
            end
            las_pkg::ST_RUN:
            begin
                if (run_done && (op_reg == las_pkg::REQ_ADVANCE) &&
                    (hc < SH'(MAX_HEIGHT)))
                begin
                    // rows from grid_height up are dead after an advance
                    clr_idx_next = HW'(hc);
                    clr_rsp_next = 1'b1;
                end
            end
            las_pkg::ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= las_pkg::ST_CLEAR;
            iss_reg       <= '0;
            fed_reg       <= '0;
            feed_vld_reg  <= 1'b0;
            wb_vld_reg    <= 1'b0;
            clr_idx_reg   <= '0;
            clr_rsp_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            fed_reg       <= fed_next;
            feed_vld_reg  <= feed_vld_next;
            wb_vld_reg    <= wb_vld_next;
            clr_idx_reg   <= clr_idx_next;
            clr_rsp_reg   <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg     <= req.req_type;
            x_idx_reg  <= XW'(req.cell_x);
            y_idx_reg  <= HW'(req.cell_y);
            value_reg  <= req.cell_value;
            inside_reg <= (SW'(req.cell_x) < wc) && (SH'(req.cell_y) < hc);
        end
        if (issuing)
        begin
            feed_src_reg <= iss_src;
        end
        if (feeding)
        begin
            wb_row_reg <= HW'(fed_reg - CW'(2));
            // the second row fed during an advance is grid row 0
            if (fed_reg == CW'(1))
            begin
                save_row_reg <= feed_row;
            end
        end
        if ((state_reg == las_pkg::ST_FINISH) && rsp_free)
        begin
            rsp_reg.request_done   <= (op_reg != las_pkg::REQ_NONE);
            rsp_reg.read_value     <= (op_reg == las_pkg::REQ_READ) && inside_reg &&
                                      sel_alive;
            rsp_reg.neighbor_count <= ((op_reg == las_pkg::REQ_READ) && inside_reg) ?
                                      sel_count : '0;
        end
    end

    // ------------------------------------------------------------------
    // Row memory
    // ------------------------------------------------------------------
    logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[iss_addr];
        end
    end

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    assign row_ctrl.shift = feeding;
    assign row_ctrl.wrap  = wrap_edges_reg;

    las_row #(
        .WIDTH (MAX_WIDTH),
        .XW    (XW)
    ) u_row (
        .clk       (clk),
        .ctrl      (row_ctrl),
        .row_in    (feed_row),
        .w_m1      (w_m1),
        .sel_x     (x_idx_reg),
        .row_next  (row_next),
        .sel_alive (sel_alive),
        .sel_count (sel_count)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (wr_addr == iss_addr)))
        else $error("row read and write hit the same address");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == las_pkg::ST_FINISH))
        else $error("response raised outside finish");

    a_feed_behind_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == las_pkg::ST_RUN) |-> (fed_reg <= iss_reg))
        else $error("window fed more rows than were issued");

    a_wb_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        wb_vld_reg |-> (SH'(wb_row_reg) < hc))
        else $error("advance write-back beyond grid height");

endmodule

// ===== tb/tb_life_automaton_step.sv =====
`timescale 1ns / 100ps

// Checks the Game of Life engine word by word against a behavioral grid model
// kept in this bench. A short scripted sequence hits the corners, the no-op
// code, out-of-grid access and the narrow torus cases. Random phases follow.
// Each phase reprograms the grid and seeds a pattern, then mixes reads,
// writes and advances.
module tb_life_automaton_step;

    localparam int GRID_MAX     = 64;
    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 80;      // a bit more than one advance
    localparam int MAX_REPORTS  = 30;

    // Index 3 maps to no register; writes there must change nothing.
    localparam logic [las_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // Plain acknowledge: write, advance, or read outside the grid.
    localparam las_pkg::las_rsp_word_t RSP_ACK = {1'b0, 4'd0, 1'b1};
    // No-op code: every field zero.
    localparam las_pkg::las_rsp_word_t RSP_NOP = '0;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    las_pkg::las_req_word_t         req;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    las_pkg::las_rsp_word_t         rsp;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [las_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [las_pkg::CFG_DATA_W-1:0] cfg_data;

    life_automaton_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grid model: live cells plus the three registers as last written.
    // ------------------------------------------------------------------
    logic [GRID_MAX-1:0] life_grid [GRID_MAX];
    logic [6:0]          cols_cfg;
    logic [6:0]          rows_cfg;
    logic                torus_cfg;

    las_pkg::las_rsp_word_t pending_rsp [$];     // responses still owed, oldest first
    las_pkg::las_rsp_word_t head_rsp;
    int            err_count   = 0;
    int            words_sent  = 0;
    int            cycle_count = 0;
    logic          send_calm   = 1'b0;  // sender runs back to back
    logic          rsp_calm    = 1'b0;  // receiver starts no new stall bursts
    int            stall_left  = 0;

    // Size registers: 0 acts as 1, anything above the grid acts as the max.
    function automatic int clamp_dim(logic [6:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return int'(v);
    endfunction

    // Moore neighbors. On a torus 1 or 2 cells wide the same cell can be hit
    // more than once, including the center itself.
    function automatic logic [3:0] live_around(int x, int y, int w, int h);
        logic [3:0] n;
        int         nx;
        int         ny;
        n = '0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                nx = x + dx;
                ny = y + dy;
                if (torus_cfg)
                begin
                    if (nx < 0)  nx += w;
                    if (nx >= w) nx -= w;
                    if (ny < 0)  ny += h;
                    if (ny >= h) ny -= h;
                end
                if (!(dx == 0 && dy == 0) && nx >= 0 && nx < w && ny >= 0 && ny < h)
                    n = n + 4'(life_grid[ny][nx]);
            end
        end
        return n;
    endfunction

    // Applies one request word to the model and returns the owed response.
    function automatic las_pkg::las_rsp_word_t life_response(las_pkg::las_req_word_t w);
        las_pkg::las_rsp_word_t r;
        logic [GRID_MAX-1:0]    nxt [GRID_MAX];
        logic [3:0]             n;
        int                     cw;
        int                     ch;
        logic                   hit;
        cw  = clamp_dim(cols_cfg);
        ch  = clamp_dim(rows_cfg);
        hit = (w.cell_x < cw) && (w.cell_y < ch);
        r   = '0;
        case (w.req_type)
            las_pkg::REQ_WRITE:
            begin
                if (hit)
                    life_grid[w.cell_y][w.cell_x] = w.cell_value;
                r.request_done = 1'b1;
            end
            las_pkg::REQ_READ:
            begin
                if (hit)
                begin
                    r.read_value     = life_grid[w.cell_y][w.cell_x];
                    r.neighbor_count = live_around(w.cell_x, w.cell_y, cw, ch);
                end
                r.request_done = 1'b1;
            end
            las_pkg::REQ_ADVANCE:
            begin
                // cells outside the used area come back dead
                for (int row = 0; row < GRID_MAX; row++)
                    nxt[row] = '0;
                for (int row = 0; row < ch; row++)
                begin
                    for (int col = 0; col < cw; col++)
                    begin
                        n = live_around(col, row, cw, ch);
                        nxt[row][col] = (n == 3) || (n == 2 && life_grid[row][col]);
                    end
                end
                for (int row = 0; row < GRID_MAX; row++)
                    life_grid[row] = nxt[row];
                r.request_done = 1'b1;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scripted words. Rows with a typed-in response use it; the others
    // take what the model says.
    // ------------------------------------------------------------------
    typedef struct {
        logic                           is_cfg;
        logic [las_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [las_pkg::CFG_DATA_W-1:0] cfg_val;
        las_pkg::las_req_word_t         word;
        logic                           fixed;
        las_pkg::las_rsp_word_t         want;
    } script_row_t;

    script_row_t script [$];

    function automatic void add_req(las_pkg::las_req_t t, int x, int y, logic v,
                                    logic fixed = 1'b0,
                                    las_pkg::las_rsp_word_t want = '0);
        script_row_t r;
        r.is_cfg          = 1'b0;
        r.cfg_idx         = '0;
        r.cfg_val         = '0;
        r.word.req_type   = t;
        r.word.cell_x     = x[5:0];
        r.word.cell_y     = y[5:0];
        r.word.cell_value = v;
        r.fixed           = fixed;
        r.want            = want;
        script.push_back(r);
    endfunction

    function automatic void add_cfg(las_pkg::las_cfg_t idx, int val);
        script_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val[6:0];
        r.word    = '0;
        r.fixed   = 1'b0;
        r.want    = '0;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------
    // Mostly short idles, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Small grids dominate so patterns are dense; extremes and the
    // out-of-range codes show up regularly.
    function automatic logic [6:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 7'($urandom_range(1, 8));
        if (r < 68)
            return 7'd0;
        if (r < 76)
            return 7'd64;
        if (r < 82)
            return 7'd127;
        if (r < 90)
            return 7'($urandom_range(65, 127));
        return 7'($urandom_range(9, 64));
    endfunction

    // Seeding words are writes of mostly live cells; otherwise a mix
    // weighted to reads and advances, with a trickle of no-ops.
    function automatic las_pkg::las_req_word_t pick_word(logic seeding);
        las_pkg::las_req_word_t w;
        int                     r;
        int                     cw;
        int                     ch;
        cw = clamp_dim(cols_cfg);
        ch = clamp_dim(rows_cfg);
        if ($urandom_range(0, 99) < 85)
        begin
            w.cell_x = 6'($urandom_range(0, cw - 1));
            w.cell_y = 6'($urandom_range(0, ch - 1));
        end
        else
        begin
            w.cell_x = 6'($urandom_range(0, 63));
            w.cell_y = 6'($urandom_range(0, 63));
        end
        w.cell_value = seeding ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) != 0);
        r = seeding ? 0 : $urandom_range(0, 99);
        if (r < 25)
            w.req_type = las_pkg::REQ_WRITE;
        else if (r < 75)
            w.req_type = las_pkg::REQ_READ;
        else if (r < 95)
            w.req_type = las_pkg::REQ_ADVANCE;
        else
            w.req_type = las_pkg::REQ_NONE;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All of them are entered and left at a falling edge.
    // ------------------------------------------------------------------
    // Holds the word until taken, logs what it owes, then maybe idles.
    // Valid stays up when no idle follows, so back-to-back words never
    // see valid dropped and raised in one step.
    task automatic send_word(las_pkg::las_req_word_t w, las_pkg::las_rsp_word_t want);
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp.push_back(want);
        words_sent++;
        @(negedge clk);
        if (!send_calm && $urandom_range(0, 99) < 35)
        begin
            req_valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    // Sender goes quiet until every owed response is back.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp.size() != 0);
    endtask

    task automatic write_reg(logic [las_pkg::CFG_IDX_W-1:0] idx,
                             logic [las_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            las_pkg::CFG_GRID_WIDTH:  cols_cfg  = val;
            las_pkg::CFG_GRID_HEIGHT: rows_cfg  = val;
            las_pkg::CFG_WRAP_EDGES:  torus_cfg = val[0];
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        if (err_count < MAX_REPORTS)
            $display("%0t: %0s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts, with calm stretches that toggle
    // now and then so long runs of full-rate draining also occur.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if ($urandom_range(0, 399) == 0)
            rsp_calm <= ~rsp_calm;
        if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left  = stall_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (!rsp_calm && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // A response word is taken on a rising edge with valid up and no stall.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                flag_mismatch("response word with nothing owed", int'(rsp), 0);
            else
            begin
                head_rsp = pending_rsp.pop_front();
                if (rsp.read_value !== head_rsp.read_value)
                    flag_mismatch("read_value", int'(rsp.read_value),
                                  int'(head_rsp.read_value));
                if (rsp.neighbor_count !== head_rsp.neighbor_count)
                    flag_mismatch("neighbor_count", int'(rsp.neighbor_count),
                                  int'(head_rsp.neighbor_count));
                if (rsp.request_done !== head_rsp.request_done)
                    flag_mismatch("request_done", int'(rsp.request_done),
                                  int'(head_rsp.request_done));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_life_automaton_step: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        script_row_t            row;
        las_pkg::las_req_word_t w;
        las_pkg::las_rsp_word_t model_rsp;
        int                     burst;
        int                     target;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        for (int i = 0; i < GRID_MAX; i++)
            life_grid[i] = '0;
        cols_cfg  = las_pkg::CFG_SIZE_RESET;
        rows_cfg  = las_pkg::CFG_SIZE_RESET;
        torus_cfg = 1'b0;

        // fresh grid is all dead, at both corners
        add_req(las_pkg::REQ_READ, 0, 0, 1'b0, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_READ, 63, 63, 1'b1, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_NONE, 63, 63, 1'b1, 1'b1, RSP_NOP);
        // L shape in the top left corner plus the far corner cell
        add_req(las_pkg::REQ_WRITE, 0, 0, 1'b1, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_WRITE, 1, 0, 1'b1, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_WRITE, 0, 1, 1'b1, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_WRITE, 63, 63, 1'b1, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_READ, 1, 1, 1'b0);
        add_req(las_pkg::REQ_ADVANCE, 0, 0, 1'b0, 1'b1, RSP_ACK);
        add_req(las_pkg::REQ_READ, 1, 1, 1'b0);
        // single column torus: width 0 acts as 1, height above max as 64
        add_cfg(las_pkg::CFG_GRID_WIDTH, 0);
        add_cfg(las_pkg::CFG_GRID_HEIGHT, 127);
        add_cfg(las_pkg::CFG_WRAP_EDGES, 1);
        add_req(las_pkg::REQ_READ, 0, 0, 1'b0);
        add_req(las_pkg::REQ_WRITE, 5, 0, 1'b1, 1'b1, RSP_ACK);   // outside: ignored
        add_req(las_pkg::REQ_READ, 5, 0, 1'b0, 1'b1, RSP_ACK);    // outside: zeros
        add_req(las_pkg::REQ_ADVANCE, 0, 0, 1'b0);
        add_req(las_pkg::REQ_READ, 0, 5, 1'b0);
        // 2x2 torus, each neighbor hit several times
        add_cfg(las_pkg::CFG_GRID_WIDTH, 2);
        add_cfg(las_pkg::CFG_GRID_HEIGHT, 2);
        add_req(las_pkg::REQ_WRITE, 1, 1, 1'b1);
        add_req(las_pkg::REQ_READ, 0, 0, 1'b0);
        add_req(las_pkg::REQ_ADVANCE, 0, 0, 1'b0);
        add_req(las_pkg::REQ_READ, 1, 1, 1'b0);
        // back to full size with dead borders; far corner was cleared
        add_cfg(las_pkg::CFG_GRID_WIDTH, 64);
        add_cfg(las_pkg::CFG_GRID_HEIGHT, 64);
        add_cfg(las_pkg::CFG_WRAP_EDGES, 0);
        add_req(las_pkg::REQ_READ, 63, 63, 1'b0);
        add_req(las_pkg::REQ_WRITE, 0, 0, 1'b0);
        add_req(las_pkg::REQ_READ, 0, 0, 1'b0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Block clears its memory after reset; the first word simply waits
        // on stall until it is ready.
        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.cfg_idx, row.cfg_val);
            end
            else
            begin
                w = row.word;
                model_rsp = life_response(w);
                send_word(w, row.fixed ? row.want : model_rsp);
            end
        end

        // Random phases: reprogram while idle, seed, then evolve and probe.
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            settle();
            write_reg(las_pkg::CFG_GRID_WIDTH, pick_dim());
            write_reg(las_pkg::CFG_GRID_HEIGHT, pick_dim());
            write_reg(las_pkg::CFG_WRAP_EDGES, 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_SPARE_IDX, 7'($urandom_range(0, 127)));
            send_calm = ($urandom_range(0, 3) == 0);
            burst     = $urandom_range(30, 60);
            for (int k = 0; k < burst; k++)
            begin
                w = pick_word(k < burst / 4);
                // now and then hold off until everything owed is back
                if ($urandom_range(0, 99) < 3)
                    settle();
                model_rsp = life_response(w);
                send_word(w, model_rsp);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("tb_life_automaton_step: done, clean");
        else
            $display("tb_life_automaton_step: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/las_pkg.sv
design/las_cell.sv
design/las_row.sv
design/life_automaton_step.sv
tb/tb_life_automaton_step.sv
